// File: sv/ific_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ific_pkg
// Shared types and codes for the IRQ/FIQ interrupt controller.
// ----------------------------------------------------------------------------
package ific_pkg;

    // Item kinds carried on the input tuser
    typedef enum logic [1:0] {
        OP_PIN   = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    // Register code within one path half
    typedef enum logic [2:0] {
        REG_SOURCE   = 3'd0,
        REG_ENABLE   = 3'd1,
        REG_CLEAR    = 3'd2,
        REG_MODE     = 3'd3,
        REG_POLARITY = 3'd4,
        REG_STATUS   = 3'd5
    } t_reg_code;

    // Selector layout: path*PATH_REGS + half*HALF_REGS + reg
    localparam logic [4:0] HALF_REGS  = 5'd6;
    localparam logic [4:0] PATH_REGS  = 5'd12;
    localparam logic [4:0] NUM_SELECT = 5'd24;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    // One input item
    typedef struct packed {
        t_opcode     opcode;
        logic [5:0]  pin_number;
        logic        pin_level;
        logic [4:0]  reg_select;
        logic [31:0] write_data;
    } t_item;

    // Decoded register access for one path
    typedef struct packed {
        logic      rd;
        logic      wr;
        logic      half;
        t_reg_code code;
    } t_access;

endpackage
`default_nettype wire

// File: sv/ific_path.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ific_path
// Source, enable, mode and polarity registers of one output path, with the
// pin event update, register read mux and the path's output line.
// ----------------------------------------------------------------------------
module ific_path #(
    parameter int NUM_SOURCES = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_en,
    input  wire                    i_pin_evt,
    input  wire [NUM_SOURCES-1:0]  i_pin_bit,
    input  wire                    i_pin_level,
    input  wire [NUM_SOURCES-1:0]  i_pin_state,
    input  ific_pkg::t_access      i_acc,
    input  wire [31:0]             i_write_data,
    output logic [31:0]            o_read_data,
    output logic                   o_line
);
    import ific_pkg::*;

    logic [NUM_SOURCES-1:0] r_src, r_ena, r_mode, r_pol;
    logic [NUM_SOURCES-1:0] n_src, n_ena, n_mode, n_pol;
    logic [NUM_SOURCES-1:0] lvl_vec, edge_hit, lvl_bits, edge_bits, clr_bits;
    logic [63:0]            clr_wide;

    // Zero-extend a source vector to 64 bits
    function automatic logic [63:0] widen(input logic [NUM_SOURCES-1:0] v);
        logic [63:0] w;
        w = '0;
        w[NUM_SOURCES-1:0] = v;
        return w;
    endfunction

    function automatic logic [31:0] get_half(input logic [NUM_SOURCES-1:0] v,
                                             input logic h);
        logic [63:0] w;
        w = widen(v);
        return h ? w[63:32] : w[31:0];
    endfunction

    function automatic logic [NUM_SOURCES-1:0] put_half(
        input logic [NUM_SOURCES-1:0] v, input logic h, input logic [31:0] d);
        logic [63:0] w;
        w = widen(v);
        if (h) begin
            w[63:32] = d;
        end else begin
            w[31:0] = d;
        end
        return w[NUM_SOURCES-1:0];
    endfunction

    // Pin event terms: active level and selected edge per source
    always_comb begin
        lvl_vec   = {NUM_SOURCES{i_pin_level}};
        edge_hit  = (r_pol & i_pin_state & ~lvl_vec) | (~r_pol & ~i_pin_state & lvl_vec);
        lvl_bits  = i_pin_bit & ~r_mode;
        edge_bits = i_pin_bit & r_mode & edge_hit;
        clr_wide  = i_acc.half ? {i_write_data, 32'd0} : {32'd0, i_write_data};
        clr_bits  = clr_wide[NUM_SOURCES-1:0] & r_mode;
    end

    // Next register values
    always_comb begin
        n_src  = r_src;
        n_ena  = r_ena;
        n_mode = r_mode;
        n_pol  = r_pol;
        if (i_pin_evt) begin
            n_src = (r_src & ~lvl_bits) | (lvl_bits & (lvl_vec ^ r_pol)) | edge_bits;
        end else if (i_acc.wr) begin
            case (i_acc.code)
                REG_SOURCE:   n_src  = put_half(r_src, i_acc.half, i_write_data);
                REG_ENABLE:   n_ena  = put_half(r_ena, i_acc.half, i_write_data);
                REG_CLEAR:    n_src  = r_src & ~clr_bits;
                REG_MODE:     n_mode = put_half(r_mode, i_acc.half, i_write_data);
                REG_POLARITY: n_pol  = put_half(r_pol, i_acc.half, i_write_data);
                default:      n_src  = r_src;
            endcase
        end
    end

    // Read mux; clear reads as zero
    always_comb begin
        o_read_data = 32'd0;
        if (i_acc.rd) begin
            case (i_acc.code)
                REG_SOURCE:   o_read_data = get_half(r_src, i_acc.half);
                REG_ENABLE:   o_read_data = get_half(r_ena, i_acc.half);
                REG_MODE:     o_read_data = get_half(r_mode, i_acc.half);
                REG_POLARITY: o_read_data = get_half(r_pol, i_acc.half);
                REG_STATUS:   o_read_data = get_half(r_src & r_ena, i_acc.half);
                default:      o_read_data = 32'd0;
            endcase
        end
    end

    // Line level after this item
    assign o_line = |(n_src & n_ena);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src  <= '0;
            r_ena  <= '0;
            r_mode <= '0;
            r_pol  <= '0;
        end else if (i_en) begin
            r_src  <= n_src;
            r_ena  <= n_ena;
            r_mode <= n_mode;
            r_pol  <= n_pol;
        end
    end

endmodule
`default_nettype wire

// File: sv/irq_fiq_interrupt_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irq_fiq_interrupt_controller_core
// IRQ/FIQ interrupt controller: pin events and register accesses arrive as
// stream items, each answered by one result with read data and both lines.
// ----------------------------------------------------------------------------
// Pipeline: input register, then state update into the result register.
// Throughput: one item per cycle while the result stream is not stalled;
// the state update is bitwise logic on the per-source registers.
// Reset: synchronous active low; clears all source, enable, mode, polarity
// and pin registers and empties both stages.
module irq_fiq_interrupt_controller_core #(
    parameter int NUM_SOURCES = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // Input stream
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata: [5:0] pin_number, [6] pin_level, [11:7] reg_select,
    //        [43:12] write_data, [47:44] zero
    input  wire [ific_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // tuser: [1:0] opcode
    input  wire [ific_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    // tdata: [31:0] read_data, [32] irq_out, [33] fiq_out, [39:34] zero
    output logic [ific_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);
    import ific_pkg::*;

    logic                   r_in_vld;
    t_item                  r_item;
    logic                   r_out_vld;
    logic [31:0]            r_rd_data;
    logic                   r_irq, r_fiq;
    logic [NUM_SOURCES-1:0] r_pin_state, n_pin_state;
    logic [NUM_SOURCES-1:0] pin_bit;
    logic                   adv, pin_evt, sel_ok, sel_fiq;
    logic [4:0]             sel_rem, sel_reg;
    t_access                acc_irq, acc_fiq;
    logic [31:0]            rd_irq, rd_fiq;
    logic                   line_irq, line_fiq;

    // Handshake: stage 2 advances when the result slot is free or taken
    assign adv             = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_fiq, r_irq, r_rd_data};

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_item.opcode     <= t_opcode'(i_s_axis_tuser[1:0]);
            r_item.pin_number <= i_s_axis_tdata[5:0];
            r_item.pin_level  <= i_s_axis_tdata[6];
            r_item.reg_select <= i_s_axis_tdata[11:7];
            r_item.write_data <= i_s_axis_tdata[43:12];
        end
    end

    // One-hot pin select; pins beyond the source count select nothing
    always_comb begin
        for (int i = 0; i < NUM_SOURCES; i++) begin
            pin_bit[i] = (r_item.pin_number == 6'(i));
        end
    end

    // Selector decode into path, half and register code
    always_comb begin
        pin_evt = (r_item.opcode == OP_PIN);
        sel_ok  = (r_item.reg_select < NUM_SELECT);
        sel_fiq = (r_item.reg_select >= PATH_REGS);
        sel_rem = sel_fiq ? (r_item.reg_select - PATH_REGS) : r_item.reg_select;

        acc_irq.half = (sel_rem >= HALF_REGS);
        sel_reg      = acc_irq.half ? (sel_rem - HALF_REGS) : sel_rem;
        acc_irq.code = t_reg_code'(sel_reg[2:0]);
        acc_irq.rd   = sel_ok && !sel_fiq && (r_item.opcode == OP_READ);
        acc_irq.wr   = sel_ok && !sel_fiq && (r_item.opcode == OP_WRITE);

        acc_fiq      = acc_irq;
        acc_fiq.rd   = sel_ok && sel_fiq && (r_item.opcode == OP_READ);
        acc_fiq.wr   = sel_ok && sel_fiq && (r_item.opcode == OP_WRITE);
    end

    ific_path #(.NUM_SOURCES(NUM_SOURCES)) u_irq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_in_vld && adv),
        .i_pin_evt    (pin_evt),
        .i_pin_bit    (pin_bit),
        .i_pin_level  (r_item.pin_level),
        .i_pin_state  (r_pin_state),
        .i_acc        (acc_irq),
        .i_write_data (r_item.write_data),
        .o_read_data  (rd_irq),
        .o_line       (line_irq)
    );

    ific_path #(.NUM_SOURCES(NUM_SOURCES)) u_fiq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (r_in_vld && adv),
        .i_pin_evt    (pin_evt),
        .i_pin_bit    (pin_bit),
        .i_pin_level  (r_item.pin_level),
        .i_pin_state  (r_pin_state),
        .i_acc        (acc_fiq),
        .i_write_data (r_item.write_data),
        .o_read_data  (rd_fiq),
        .o_line       (line_fiq)
    );

    // Last seen pin levels
    always_comb begin
        n_pin_state = r_pin_state;
        if (pin_evt) begin
            n_pin_state = r_item.pin_level ? (r_pin_state | pin_bit)
                                           : (r_pin_state & ~pin_bit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin_state <= '0;
        end else if (r_in_vld && adv) begin
            r_pin_state <= n_pin_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld && adv) begin
            r_rd_data <= rd_irq | rd_fiq;
            r_irq     <= line_irq;
            r_fiq     <= line_fiq;
        end
    end

endmodule
`default_nettype wire
